[hw/rtl/fourth_order_iir_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter: assertion macros
// Shared concurrent assertion forms used by the filter RTL. Each macro
// expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FOURTH_ORDER_IIR_FILTER_TOP_DEFINES_SVH
`define FOURTH_ORDER_IIR_FILTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FIIR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FIIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fiir_pkg.sv]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter package
// Shared constants, register indexes and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package fiir_pkg;

	// Default widths of samples and coefficients.
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 24;

	// Coefficients carry this many integer bits, the rest is fraction.
	localparam int COEF_INT_BITS = 4;

	// Extra fraction bits kept on the stored output history.
	localparam int HIST_FRAC = 8;

	// Tap counts.
	localparam int NUM_FF   = 5;
	localparam int NUM_HIST = 4;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FF_TAPS_0_1 = 3'd0,
		REG_FF_TAPS_2_3 = 3'd1,
		REG_FF_TAP_4    = 3'd2,
		REG_FB_TAPS_1_2 = 3'd3,
		REG_FB_TAPS_3_4 = 3'd4
	} reg_index_t;

	// Pipeline control from the top level to the datapath stages.
	typedef struct packed {
		logic load;     // a new sample enters the first stage
		logic advance;  // the first stage moves into the output register
	} pipe_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/fiir_ff.sv]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter: feedforward stage
// Keeps the input history and registers the five-tap feedforward sum of
// each new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module fiir_ff import fiir_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
	localparam int FF_W        = COEF_WIDTH + SAMPLE_WIDTH + 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pipe_ctrl_t                     ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic signed [COEF_WIDTH-1:0]   ff_coef [NUM_FF],
	output logic signed [FF_W-1:0]              ff_sum_s1
);

	logic signed [SAMPLE_WIDTH-1:0] x_hist_q [NUM_HIST];
	logic signed [FF_W-1:0]         term [NUM_FF];
	logic signed [FF_W-1:0]         ff_sum;

	// Products of the coefficients with the new sample and the history.
	always_comb begin
		term[0] = FF_W'(ff_coef[0]) * FF_W'(sample_in);
		for (int i = 0; i < NUM_HIST; i++) begin
			term[i+1] = FF_W'(ff_coef[i+1]) * FF_W'(x_hist_q[i]);
		end
	end

	// Sum of the five products.
	always_comb begin
		ff_sum = '0;
		for (int i = 0; i < NUM_FF; i++) begin
			ff_sum = ff_sum + term[i];
		end
	end

	// Input history shifts on every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HIST; i++) begin
				x_hist_q[i] <= '0;
			end
		end else if (ctrl.load) begin
			x_hist_q[0] <= sample_in;
			for (int i = 1; i < NUM_HIST; i++) begin
				x_hist_q[i] <= x_hist_q[i-1];
			end
		end
	end

	// Stage register for the feedforward sum.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ff_sum_s1 <= ff_sum;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/fiir_fb.sv]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter: feedback and output stage
// Subtracts the feedback terms, rounds and saturates the new output,
// keeps the output history and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fiir_fb import fiir_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
	localparam int FF_W        = COEF_WIDTH + SAMPLE_WIDTH + 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pipe_ctrl_t                     ctrl,
	input  wire logic signed [FF_W-1:0]         ff_sum_s1,
	input  wire logic signed [COEF_WIDTH-1:0]   fb_coef [NUM_HIST],
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped
);

	localparam int HIST_W    = SAMPLE_WIDTH + HIST_FRAC;
	localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
	localparam int ACC_W     = FF_W + HIST_FRAC + 1;
	localparam int YE_W      = ACC_W - COEF_FRAC;
	localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [HIST_W:0]   HIST_HALF = (HIST_W + 1)'(1) <<< (HIST_FRAC - 1);
	localparam logic signed [HIST_W-1:0] HIST_MAX  = {1'b0, {(HIST_W - 1){1'b1}}};
	localparam logic signed [HIST_W-1:0] HIST_MIN  = {1'b1, {(HIST_W - 1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic signed [HIST_W-1:0]       y_hist_q [NUM_HIST];
	logic signed [ACC_W-1:0]        fb_term [NUM_HIST];
	logic signed [ACC_W-1:0]        fb_sum;
	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0]        acc_rnd;
	logic signed [YE_W-1:0]         yext_full;
	logic                           hist_fits;
	logic signed [HIST_W-1:0]       yext;
	logic signed [HIST_W:0]         yext_rnd;
	logic signed [SAMPLE_WIDTH:0]   y_full;
	logic                           out_fits;
	logic signed [SAMPLE_WIDTH-1:0] y;

	// Feedback products over the stored outputs.
	always_comb begin
		for (int i = 0; i < NUM_HIST; i++) begin
			fb_term[i] = ACC_W'(fb_coef[i]) * ACC_W'(y_hist_q[i]);
		end
	end

	// Feedback sum and alignment of the feedforward sum to history units.
	always_comb begin
		fb_sum = '0;
		for (int i = 0; i < NUM_HIST; i++) begin
			fb_sum = fb_sum + fb_term[i];
		end
		acc = (ACC_W'(ff_sum_s1) <<< HIST_FRAC) - fb_sum;
	end

	// Round half up to history precision and saturate to the history width.
	always_comb begin
		acc_rnd   = acc + ACC_HALF;
		yext_full = YE_W'(acc_rnd >>> COEF_FRAC);
		hist_fits = (yext_full == YE_W'(signed'(yext_full[HIST_W-1:0])));
		if (hist_fits) begin
			yext = yext_full[HIST_W-1:0];
		end else if (yext_full[YE_W-1]) begin
			yext = HIST_MIN;
		end else begin
			yext = HIST_MAX;
		end
	end

	// Round half up to a sample and saturate to the sample width.
	always_comb begin
		yext_rnd = (HIST_W + 1)'(yext) + HIST_HALF;
		y_full   = yext_rnd[HIST_W:HIST_FRAC];
		out_fits = (y_full == (SAMPLE_WIDTH + 1)'(signed'(y_full[SAMPLE_WIDTH-1:0])));
		if (out_fits) begin
			y = y_full[SAMPLE_WIDTH-1:0];
		end else if (y_full[SAMPLE_WIDTH]) begin
			y = OUT_MIN;
		end else begin
			y = OUT_MAX;
		end
	end

	// Output history shifts as each result is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HIST; i++) begin
				y_hist_q[i] <= '0;
			end
		end else if (ctrl.advance) begin
			y_hist_q[0] <= yext;
			for (int i = 1; i < NUM_HIST; i++) begin
				y_hist_q[i] <= y_hist_q[i-1];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			sample_out <= y;
			clipped    <= !(hist_fits && out_fits);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/fourth_order_iir_filter_top.sv]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter, top level
// Direct form I filter with five feedforward and four feedback taps,
// rounded and saturated output with a clip flag.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_valid/in_ready channel and results leave on the
//   out_valid/out_ready channel, one result per input transaction, in order.
//   Coefficients are written on the cfg_valid/cfg_ready channel, which is
//   always ready; cfg_index selects the register, unknown indexes are ignored.
//   Write coefficients only while no sample is in flight.
//   The feedforward stage register is loaded at the edge that accepts a
//   sample, and the feedback stage then loads the result register when the
//   first stage advances, which raises out_valid. Throughput is one sample
//   per cycle while the receiver keeps up; the limit is the feedback loop,
//   which closes through the output history.
//   When the receiver stalls, the result register holds and the feedforward
//   stage fills; in_ready drops only when both are full.
//   Reset clears both histories, sets a0 to 1.0 and all other coefficients
//   to zero, and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fourth_order_iir_filter_top_defines.svh"

module fourth_order_iir_filter_top import fiir_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]         cfg_index,
	input  wire logic [2*COEF_WIDTH-1:0]        cfg_data,
	// sample input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped
);

	localparam int FF_W = COEF_WIDTH + SAMPLE_WIDTH + 3;
	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
		COEF_WIDTH'(1) <<< (COEF_WIDTH - COEF_INT_BITS);
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic signed [COEF_WIDTH-1:0] ff_coef_q [NUM_FF];
	logic signed [COEF_WIDTH-1:0] fb_coef_q [NUM_HIST];
	logic                         valid_s1;
	logic                         out_valid_q;
	logic signed [FF_W-1:0]       ff_sum_s1;
	pipe_ctrl_t                   ctrl;

	// Pipeline handshake: the first stage advances whenever the result
	// register is empty or being drained.
	always_comb begin
		ctrl.advance = valid_s1 && (!out_valid_q || out_ready);
		in_ready     = !valid_s1 || ctrl.advance;
		ctrl.load    = in_valid && in_ready;
		out_valid    = out_valid_q;
		cfg_ready    = 1'b1;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				valid_s1 <= 1'b1;
			end else if (ctrl.advance) begin
				valid_s1 <= 1'b0;
			end
			if (ctrl.advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FF; i++) begin
				ff_coef_q[i] <= '0;
			end
			ff_coef_q[0] <= COEF_ONE;
			for (int i = 0; i < NUM_HIST; i++) begin
				fb_coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_FF_TAPS_0_1: begin
					ff_coef_q[0] <= cfg_data[COEF_WIDTH-1:0];
					ff_coef_q[1] <= cfg_data[2*COEF_WIDTH-1:COEF_WIDTH];
				end
				REG_FF_TAPS_2_3: begin
					ff_coef_q[2] <= cfg_data[COEF_WIDTH-1:0];
					ff_coef_q[3] <= cfg_data[2*COEF_WIDTH-1:COEF_WIDTH];
				end
				REG_FF_TAP_4: begin
					ff_coef_q[4] <= cfg_data[COEF_WIDTH-1:0];
				end
				REG_FB_TAPS_1_2: begin
					fb_coef_q[0] <= cfg_data[COEF_WIDTH-1:0];
					fb_coef_q[1] <= cfg_data[2*COEF_WIDTH-1:COEF_WIDTH];
				end
				REG_FB_TAPS_3_4: begin
					fb_coef_q[2] <= cfg_data[COEF_WIDTH-1:0];
					fb_coef_q[3] <= cfg_data[2*COEF_WIDTH-1:COEF_WIDTH];
				end
				default: begin
				end
			endcase
		end
	end

	// Feedforward stage.
	fiir_ff #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_ff (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample_in(sample_in),
		.ff_coef  (ff_coef_q),
		.ff_sum_s1(ff_sum_s1)
	);

	// Feedback stage and result register.
	fiir_fb #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.ff_sum_s1 (ff_sum_s1),
		.fb_coef   (fb_coef_q),
		.sample_out(sample_out),
		.clipped   (clipped)
	);

	// An accepted sample occupies the first stage in the next cycle.
	`FIIR_ASSERT_NEXT(a_load_fills_s1, ctrl.load, valid_s1, "accepted sample lost before stage one")
	// A stage-one advance always leaves a result waiting.
	`FIIR_ASSERT_NEXT(a_advance_fills_out, ctrl.advance, out_valid_q, "advanced result not presented")
	// A clipped result always sits on one of the output rails.
	`FIIR_ASSERT_SAME(a_clip_at_rail, out_valid_q && clipped,
		(sample_out == OUT_MAX) || (sample_out == OUT_MIN), "clip flag set off the rails")

endmodule

`default_nettype wire

[bench/fourth_order_iir_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// Fourth-order IIR filter testbench
// Sends samples and coefficient writes into the filter. A fixed-point copy of
// the direct form I recursion inside the bench predicts every output, and
// each result transaction is checked in order. Both channels get random idle
// and stall bursts, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module fourth_order_iir_filter_top_tb;
	import fiir_pkg::*;

	localparam int SAMPLE_W     = SAMPLE_WIDTH_DEF;
	localparam int COEF_W       = COEF_WIDTH_DEF;
	localparam int COEF_FRAC    = COEF_W - COEF_INT_BITS;
	localparam int HIST_W       = SAMPLE_W + HIST_FRAC;
	localparam int NUM_REGS     = 5;
	localparam int UNITY        = 1 << COEF_FRAC;
	localparam int COEF_MAX     = (1 << (COEF_W - 1)) - 1;
	localparam int COEF_MIN     = -(1 << (COEF_W - 1));
	localparam int SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN   = -(1 << (SAMPLE_W - 1));
	localparam longint HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 1;
	localparam longint HIST_MIN = -HIST_MAX - 1;
	localparam int LONG_HOLD    = 64;
	localparam int MAX_PRINTED  = 100;
	localparam int FLUSH_CYCLES = 16;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_ITEMS  = 221;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} filter_result_t;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_valid  = 1'b0;
	logic                        cfg_ready;
	logic [CFG_INDEX_W-1:0]      cfg_index  = '0;
	logic [2*COEF_W-1:0]         cfg_data   = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic signed [SAMPLE_W-1:0]  sample_in  = '0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        clipped;

	// Bench copy of the coefficients and of both histories, in reset state.
	longint ff_tap [NUM_FF]        = '{UNITY, 0, 0, 0, 0};
	longint fb_tap [1:NUM_HIST]    = '{default: 0};
	longint x_hist [NUM_HIST]      = '{default: 0};
	longint y_hist [NUM_HIST]      = '{default: 0};

	logic signed [SAMPLE_W-1:0] pending_samples [$];
	filter_result_t             predicted_outputs [$];
	filter_result_t             next_output;

	int samples_queued = 0;
	int outputs_seen   = 0;
	int mismatch_count = 0;
	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;
	int tx_gap         = 0;
	int rx_stall       = 0;
	int rx_hold        = 0;
	bit long_hold_req  = 1'b0;

	int tx_idle_plan [NUM_PHASES] = '{15, 0, 25, 10, 5, 0};
	int rx_idle_plan [NUM_PHASES] = '{15, 30, 0, 10, 5, 0};

	fourth_order_iir_filter_top #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.COEF_WIDTH  (COEF_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.clipped   (clipped)
	);

	// Free-running clock, period 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sign-extend one coefficient field to full width.
	function automatic longint to_coef(input logic [COEF_W-1:0] c);
		return longint'($signed(c));
	endfunction

	// Track a register write in the bench copy of the coefficients.
	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [2*COEF_W-1:0] d);
		logic [COEF_W-1:0] low_half;
		logic [COEF_W-1:0] high_half;
		low_half  = d[COEF_W-1:0];
		high_half = d[2*COEF_W-1:COEF_W];
		case (idx)
			REG_FF_TAPS_0_1: begin
				ff_tap[0] = to_coef(low_half);
				ff_tap[1] = to_coef(high_half);
			end
			REG_FF_TAPS_2_3: begin
				ff_tap[2] = to_coef(low_half);
				ff_tap[3] = to_coef(high_half);
			end
			REG_FF_TAP_4: begin
				ff_tap[4] = to_coef(low_half);
			end
			REG_FB_TAPS_1_2: begin
				fb_tap[1] = to_coef(low_half);
				fb_tap[2] = to_coef(high_half);
			end
			REG_FB_TAPS_3_4: begin
				fb_tap[3] = to_coef(low_half);
				fb_tap[4] = to_coef(high_half);
			end
			default: begin
			end
		endcase
	endfunction

	// One filter step: exact multiply-accumulate, then two rounding and
	// saturation stages, then the history shift.
	function automatic filter_result_t filter_step(input logic signed [SAMPLE_W-1:0] x);
		longint         ff_sum;
		longint         fb_sum;
		longint         y_ext;
		longint         y_out;
		int             i;
		filter_result_t r;
		r.clip = 1'b0;
		ff_sum = ff_tap[0] * x;
		fb_sum = 0;
		for (i = 0; i < NUM_HIST; i++) begin
			ff_sum += ff_tap[i + 1] * x_hist[i];
			fb_sum += fb_tap[i + 1] * y_hist[i];
		end
		// The feedforward sum lacks the history fraction bits, so it is shifted
		// up before the feedback sum is taken off. Rounding is half up.
		y_ext = ((ff_sum <<< HIST_FRAC) - fb_sum + (64'sd1 <<< (COEF_FRAC - 1)))
			>>> COEF_FRAC;
		if (y_ext > HIST_MAX) begin
			y_ext  = HIST_MAX;
			r.clip = 1'b1;
		end else if (y_ext < HIST_MIN) begin
			y_ext  = HIST_MIN;
			r.clip = 1'b1;
		end
		y_out = (y_ext + (64'sd1 <<< (HIST_FRAC - 1))) >>> HIST_FRAC;
		if (y_out > SAMPLE_MAX) begin
			y_out  = SAMPLE_MAX;
			r.clip = 1'b1;
		end else if (y_out < SAMPLE_MIN) begin
			y_out  = SAMPLE_MIN;
			r.clip = 1'b1;
		end
		for (i = NUM_HIST - 1; i > 0; i--) begin
			x_hist[i] = x_hist[i - 1];
			y_hist[i] = y_hist[i - 1];
		end
		x_hist[0] = x;
		y_hist[0] = y_ext;
		r.sample  = y_out[SAMPLE_W-1:0];
		return r;
	endfunction

	// Mix of extremes, small values, mid-range values and full-range noise.
	function automatic int random_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return int'($urandom_range(0, 600)) - 300;
			4, 5: return int'($urandom_range(0, 8000)) - 4000;
			default: return int'($urandom);
		endcase
	endfunction

	// Random tap in the range -span to +span.
	function automatic int rand_tap(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [2*COEF_W-1:0] tap_pair(input int low_tap, input int high_tap);
		return {high_tap[COEF_W-1:0], low_tap[COEF_W-1:0]};
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// Must be called right after a rising edge. Valid stays high on return so
	// that writes can follow back to back; the caller lowers it.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [2*COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic load_taps(input int a0, input int a1, input int a2, input int a3,
			input int a4, input int b1, input int b2, input int b3, input int b4);
		write_reg(REG_FF_TAPS_0_1, tap_pair(a0, a1));
		write_reg(REG_FF_TAPS_2_3, tap_pair(a2, a3));
		write_reg(REG_FF_TAP_4, tap_pair(a4, 0));
		write_reg(REG_FB_TAPS_1_2, tap_pair(b1, b2));
		write_reg(REG_FB_TAPS_3_4, tap_pair(b3, b4));
		cfg_valid <= 1'b0;
	endtask

	// Feedforward gains up to one per tap and small feedback taps whose sum
	// of magnitudes stays below one, so the loop is stable.
	task automatic load_stable_taps();
		load_taps(rand_tap(UNITY), rand_tap(UNITY), rand_tap(UNITY), rand_tap(UNITY),
			rand_tap(UNITY), rand_tap(UNITY / 5), rand_tap(UNITY / 5),
			rand_tap(UNITY / 5), rand_tap(UNITY / 5));
	endtask

	// Queue one sample; only the low sample bits are kept.
	task automatic queue_sample(input int s);
		pending_samples.push_back(SAMPLE_W'(s));
		samples_queued++;
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			queue_sample(random_sample());
	endtask

	// Hold the sender until every queued sample has produced its result.
	task automatic wait_for_results();
		do
			@(posedge clk);
		while (outputs_seen < samples_queued);
	endtask

	// Input driver: predicts on every accepted transaction and inserts random
	// idle bursts between samples.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_outputs.push_back(filter_step(sample_in));
				if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
					tx_gap = $urandom_range(1, 9);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					in_valid  <= 1'b1;
					sample_in <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold: counts the cycles of the stretch once requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if (long_hold_req) begin
			long_hold_req <= 1'b0;
			rx_hold       <= LONG_HOLD;
		end
	end

	// Output monitor: checks each result transaction against the oldest
	// prediction and drives out_ready with stall bursts and the long hold.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				outputs_seen++;
				if (predicted_outputs.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no sample outstanding",
						sample_out));
				end else begin
					next_output = predicted_outputs.pop_front();
					if (sample_out !== next_output.sample)
						report_mismatch($sformatf("sample_out %0d, expected %0d",
							sample_out, next_output.sample));
					if (clipped !== next_output.clip)
						report_mismatch($sformatf("clipped %b, expected %b (sample %0d)",
							clipped, next_output.clip, next_output.sample));
				end
			end
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
			end else begin
				if (rx_stall == 0 && rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
					rx_stall = $urandom_range(1, 9);
				if (rx_stall > 0) begin
					rx_stall--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int phase;
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset taps form a unity filter, so every sample should come back as is.
		queue_sample(0);
		queue_sample(1);
		queue_sample(-1);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(int'(16'h5555));
		queue_sample(int'(16'hAAAA));
		queue_sample(-300);
		wait_for_results();

		// Most positive taps everywhere: history and output saturation.
		load_taps(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
			COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(0);
		queue_sample(1);
		wait_for_results();

		// Most negative taps everywhere.
		load_taps(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
			COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(SAMPLE_MIN);
		queue_sample(0);
		queue_sample(-1);
		wait_for_results();

		// A write to an unmapped index must leave every tap alone.
		write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1)),
			(2 * COEF_W)'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
		queue_sample(100);
		queue_sample(-100);
		wait_for_results();

		// Gain of one half with all other taps zero: odd inputs land exactly on a
		// half and must round up, also for negative values.
		load_taps(UNITY / 2, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_sample(1);
		queue_sample(-1);
		queue_sample(3);
		queue_sample(-3);
		wait_for_results();

		// Random phases; one uses full-range taps, the last one runs with no
		// idling at all.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 2) begin
				load_taps(rand_tap(COEF_MAX), rand_tap(COEF_MAX), rand_tap(COEF_MAX),
					rand_tap(COEF_MAX), rand_tap(COEF_MAX), rand_tap(COEF_MAX),
					rand_tap(COEF_MAX), rand_tap(COEF_MAX), rand_tap(COEF_MAX));
			end else begin
				load_stable_taps();
			end
			tx_idle_pct = tx_idle_plan[phase];
			rx_idle_pct = rx_idle_plan[phase];
			queue_random(PHASE_ITEMS);
			// Hold the output off while samples keep coming, so the pipeline
			// fills and the input side has to stall.
			if (phase == 1)
				long_hold_req = 1'b1;
			wait_for_results();
		end

		// Let any stray result show up before the verdict.
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (predicted_outputs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[fourth_order_iir_filter_top.f]
+incdir+hw/rtl
hw/rtl/fiir_pkg.sv
hw/rtl/fiir_ff.sv
hw/rtl/fiir_fb.sv
hw/rtl/fourth_order_iir_filter_top.sv
bench/fourth_order_iir_filter_top_tb.sv
